// ===== hw/rtl/afr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants for the escaped API frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] CHK_BASE   = 8'hFF;

	localparam logic [15:0] MAX_LEN_RESET = 16'd252;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		ST_PROGRESS = 3'd0,
		ST_GOOD     = 3'd1,
		ST_BADCHK   = 3'd2,
		ST_ABORT    = 3'd3,
		ST_TOOLONG  = 3'd4
	} afr_status_t;

	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_LEN_HI = 5'b00010,
		PH_LEN_LO = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_CHK    = 5'b10000
	} afr_phase_t;

	// one classified input byte: a start marker or an unescaped byte
	typedef struct packed {
		logic       is_start;
		logic [7:0] data_val;
	} afr_tok_t;

	typedef struct packed {
		logic [15:0] frame_length;
		afr_status_t frame_status;
		logic        frame_end;
		logic        first_of_frame;
		logic        is_data;
		logic [7:0]  out_byte;
	} afr_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/afr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_front
// Accepts raw bytes, strips escapes and classifies start markers.
// ----------------------------------------------------------------------------
module afr_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_data,
	output logic                 tok_valid,
	input  wire logic            tok_ready,
	output afr_pkg::afr_tok_t    tok
);
	import afr_pkg::*;

	logic esc_q;
	logic fire;

	assign in_ready = tok_ready;
	assign fire     = in_valid && tok_ready;

	// bytes seen while hunting may be mis-unescaped here; the back end drops them
	always_comb begin
		tok_valid    = 1'b0;
		tok.is_start = 1'b0;
		tok.data_val = in_data;
		if (in_data == START_BYTE) begin
			tok_valid    = in_valid;
			tok.is_start = 1'b1;
		end else if (esc_q) begin
			tok_valid    = in_valid;
			tok.data_val = in_data ^ ESC_XOR;
		end else if (in_data != ESC_BYTE) begin
			tok_valid    = in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
		end else if (fire) begin
			if (in_data == START_BYTE || esc_q) begin
				esc_q <= 1'b0;
			end else if (in_data == ESC_BYTE) begin
				esc_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/afr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_queue
// Short item queue between the front and back ends.
// ----------------------------------------------------------------------------
module afr_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_valid,
	output logic                      wr_ready,
	input  wire afr_pkg::afr_tok_t    wr_tok,
	output logic                      rd_valid,
	input  wire logic                 rd_ready,
	output afr_pkg::afr_tok_t         rd_tok
);
	import afr_pkg::*;

	afr_tok_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q;
	logic [QUEUE_AW-1:0]     rd_ptr_q;
	logic [QUEUE_AW:0]       count_q;
	logic                    push;
	logic                    pop;

	assign wr_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/afr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_back
// Frame state machine: length, data, checksum, and the registered result.
// ----------------------------------------------------------------------------
module afr_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [15:0]          cfg_wdata,
	input  wire logic                 tok_valid,
	output logic                      tok_ready,
	input  wire afr_pkg::afr_tok_t    tok,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output afr_pkg::afr_res_t         res
);
	import afr_pkg::*;

	logic [15:0] max_len_q;
	afr_phase_t  phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] seen_q, seen_d;
	logic [7:0]  sum_q, sum_d;
	logic        out_valid_q;
	afr_res_t    out_q;
	logic        emit;
	afr_res_t    res_d;
	logic        fire;
	logic [15:0] seen_inc;
	logic [15:0] len_full;
	logic [7:0]  d;

	assign tok_ready = !out_valid_q || res_ready;
	assign fire      = tok_valid && tok_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign d         = tok.data_val;
	assign seen_inc  = seen_q + 16'd1;
	assign len_full  = {len_q[15:8], d};

	always_comb begin
		phase_d              = phase_q;
		len_d                = len_q;
		seen_d               = seen_q;
		sum_d                = sum_q;
		emit                 = 1'b0;
		res_d.out_byte       = 8'd0;
		res_d.is_data        = 1'b0;
		res_d.first_of_frame = 1'b0;
		res_d.frame_end      = 1'b0;
		res_d.frame_status   = ST_PROGRESS;
		res_d.frame_length   = len_q;
		if (tok.is_start) begin
			phase_d = PH_LEN_HI;
			len_d   = 16'd0;
			seen_d  = 16'd0;
			sum_d   = 8'd0;
			if (phase_q != PH_HUNT) begin
				emit               = 1'b1;
				res_d.frame_end    = 1'b1;
				res_d.frame_status = ST_ABORT;
			end
		end else begin
			unique case (phase_q)
				PH_LEN_HI: begin
					len_d   = {d, 8'd0};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d  = len_full;
					seen_d = 16'd0;
					sum_d  = 8'd0;
					if (len_full > max_len_q) begin
						phase_d            = PH_HUNT;
						emit               = 1'b1;
						res_d.frame_end    = 1'b1;
						res_d.frame_status = ST_TOOLONG;
						res_d.frame_length = len_full;
					end else if (len_full == 16'd0) begin
						phase_d = PH_CHK;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					sum_d                = sum_q + d;
					seen_d               = seen_inc;
					emit                 = 1'b1;
					res_d.out_byte       = d;
					res_d.is_data        = 1'b1;
					res_d.first_of_frame = (seen_q == 16'd0);
					if (seen_inc >= len_q) begin
						phase_d = PH_CHK;
					end
				end
				PH_CHK: begin
					phase_d            = PH_HUNT;
					emit               = 1'b1;
					res_d.frame_end    = 1'b1;
					res_d.frame_status = (d == CHK_BASE - sum_q) ? ST_GOOD : ST_BADCHK;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= MAX_LEN_RESET;
			phase_q     <= PH_HUNT;
			len_q       <= 16'd0;
			seen_q      <= 16'd0;
			sum_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (fire) begin
				phase_q     <= phase_d;
				len_q       <= len_d;
				seen_q      <= seen_d;
				sum_q       <= sum_d;
				out_valid_q <= emit;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_q <= res_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/api_frame_rx_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// api_frame_rx_deframer
// Escaped API-mode frame receiver that streams frame bytes and frame status.
// ----------------------------------------------------------------------------
// An accepted byte is written into the queue, and its result then into the back end's output register.
// Throughput: one byte per cycle while m_axis accepts; a stall on m_axis holds the back end's
// output register, which fills the queue and so stalls s_axis, paced by the single-byte FSM step.
// Reset (arst_n low): hunting for a start byte, escape cleared, queue empty,
// max_payload_len back to 252.
module api_frame_rx_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] frame_length
	output logic [4:0]       m_axis_tuser,   // [0] is_data, [1] first_of_frame,
	                                          // [4:2] frame_status
	output logic             m_axis_tlast    // frame_end
);
	import afr_pkg::*;

	logic     f_valid, f_ready;
	afr_tok_t f_tok;
	logic     q_valid, q_ready;
	afr_tok_t q_tok;
	afr_res_t res;

	afr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	afr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_tok   (f_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_tok   (q_tok)
	);

	afr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tok_valid (q_valid),
		.tok_ready (q_ready),
		.tok       (q_tok),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {res.frame_length, res.out_byte};
	assign m_axis_tuser = {res.frame_status, res.first_of_frame, res.is_data};
	assign m_axis_tlast = res.frame_end;

endmodule
`default_nettype wire
